// ===== sv/smrq_pkg.sv =====
// Shared types, sizes and operation codes for the searchable message ring queue.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package smrq_pkg;

  localparam int SLOTS     = 256;
  localparam int WORD_BITS = 32;
  localparam int PTR_W     = $clog2(SLOTS);
  localparam int CNT_W     = (PTR_W + 1 > 9) ? PTR_W + 1 : 9;
  localparam int CAP_W     = 8;
  localparam int OCC_W     = 8;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  typedef logic [2:0]           func_t;
  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam func_t FN_PUSH     = 3'd0;
  localparam func_t FN_POP      = 3'd1;
  localparam func_t FN_FIND_H   = 3'd2;
  localparam func_t FN_FIND_X   = 3'd3;
  localparam func_t FN_INVAL    = 3'd4;
  localparam func_t FN_ERASE_H  = 3'd5;
  localparam func_t FN_ERASE_HM = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVALID  = 1'b1;

  typedef struct packed {
    word_t handle;
    word_t message;
    word_t param_a;
    word_t param_b;
  } entry_t;

  typedef struct packed {
    func_t  func;
    entry_t key;
  } req_t;

  typedef struct packed {
    logic   match;
    entry_t fix;
  } cmp_t;

  typedef struct packed {
    logic             ok;
    entry_t           ent;
    logic [OCC_W-1:0] occ;
  } rsp_t;

  // Next ring position, wrapping at the ring size n.
  function automatic ptr_t ptr_adv(ptr_t p, cnt_t n);
    cnt_t q;
    q = {{(CNT_W-PTR_W){1'b0}}, p} + cnt_t'(1);
    return (q >= n) ? '0 : q[PTR_W-1:0];
  endfunction

endpackage

// ===== sv/smrq_req_if.sv =====
// Request channel of the message ring queue: valid/ready plus the request fields.
// Depends on smrq_pkg.
`timescale 1ns / 1ps

interface smrq_req_if import smrq_pkg::*; ();
  logic  valid;
  logic  ready;
  func_t func;
  word_t handle;
  word_t message;
  word_t param_a;
  word_t param_b;

  modport source (output valid, func, handle, message, param_a, param_b, input ready);
  modport sink   (input valid, func, handle, message, param_a, param_b, output ready);
endinterface

// ===== sv/smrq_rsp_if.sv =====
// Response channel of the message ring queue: valid/ready plus the result fields.
// Depends on smrq_pkg.
`timescale 1ns / 1ps

interface smrq_rsp_if import smrq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             ok;
  word_t            out_handle;
  word_t            out_message;
  word_t            out_param_a;
  word_t            out_param_b;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, ok, out_handle, out_message, out_param_a, out_param_b,
                  occupancy, input ready);
  modport sink   (input valid, ok, out_handle, out_message, out_param_a, out_param_b,
                  occupancy, output ready);
endinterface

// ===== sv/smrq_store.sv =====
// Entry memory of the ring: one write port and one read port with registered read data.
// Depends on smrq_pkg.
`timescale 1ns / 1ps

module smrq_store import smrq_pkg::*; (
  input  logic   clk,
  input  logic   we,
  input  ptr_t   waddr,
  input  entry_t wdata,
  input  ptr_t   raddr,
  output entry_t rdata
);

  entry_t mem_r [SLOTS];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/smrq_cmp.sv =====
// Shared compare unit: matches one stored entry against the request key and
// builds the cleared entry that an edit writes back. Depends on smrq_pkg.
`timescale 1ns / 1ps

module smrq_cmp import smrq_pkg::*; (
  input  func_t  func,
  input  entry_t key,
  input  entry_t ent,
  input  word_t  inv_code,
  output cmp_t   res
);

  logic hit_h;
  logic hit_m;
  logic hit_p;

  always_comb begin
    hit_h = (ent.handle == key.handle);
    hit_m = (ent.message == key.message);
    hit_p = (ent.param_a == key.param_a) && (ent.param_b == key.param_b);

    unique case (func)
      FN_FIND_H:   res.match = hit_h;
      FN_FIND_X:   res.match = hit_h && hit_m && hit_p;
      FN_INVAL:    res.match = hit_m;
      FN_ERASE_H:  res.match = hit_h;
      FN_ERASE_HM: res.match = hit_h && hit_m;
      default:     res.match = 1'b0;
    endcase

    // Invalidation keeps the handle; both erase forms wipe it.
    res.fix.handle  = (func == FN_INVAL) ? ent.handle : '0;
    res.fix.message = inv_code;
    res.fix.param_a = '0;
    res.fix.param_b = '0;
  end

endmodule

// ===== sv/searchable_message_ring_queue_core.sv =====
// Top level of the searchable message ring queue: sequencer, ring pointers,
// configuration registers and output register. Depends on smrq_pkg, the two
// channel interfaces, smrq_store and smrq_cmp.
`timescale 1ns / 1ps

// The block is a FIFO of four-word messages with search and in-place edit.
// Requests arrive on in_req (valid/ready); each request yields exactly one
// response on out_rsp, in order, carrying ok, the popped entry (zero unless
// a pop delivered) and the occupancy after the request.
// Push and pop pass from the accept state to the execute state, in which the
// memory write port is written or the prefetched head entry is used. Searches
// and edits walk the queued entries through the one memory read port and the
// shared compare unit, one entry per cycle; a search that hits stops early.
// A new request is taken only while the sequencer is idle. The response sits
// in an output register, so the next request can be accepted while that
// response waits; if the receiver stalls longer, a finished response is
// parked in a holding state until the output register frees up.
// The configuration port writes capacity (index 0, which also empties the
// ring) or the invalid code (index 1); write it only while the block is idle.
// Reset empties the ring, sets capacity to 255 and the invalid code to zero.
// The entry memory is not cleared; only queued entries are ever used.
module searchable_message_ring_queue_core import smrq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  smrq_req_if.sink             in_req,
  smrq_rsp_if.source           out_rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  localparam cnt_t SLOTS_N = cnt_t'(SLOTS);

  logic [1:0]       state_r, state_nxt;
  req_t             req_r, req_nxt;
  ptr_t             rp_r, rp_nxt;
  ptr_t             wp_r, wp_nxt;
  cnt_t             count_r, count_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  word_t            inv_r, inv_nxt;
  ptr_t             scan_addr_r, scan_addr_nxt;
  cnt_t             left_r, left_nxt;
  logic             cmp_valid_r, cmp_valid_nxt;
  ptr_t             cmp_addr_r, cmp_addr_nxt;
  rsp_t             res_r, res_nxt;
  rsp_t             out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  cnt_t   cap_ext;
  cnt_t   ring_n;
  logic   in_fire;
  logic   out_free;
  logic   out_load;
  logic   fin;
  rsp_t   fin_res;
  logic   is_scan;
  logic   is_find;
  logic   mem_we;
  ptr_t   mem_waddr;
  entry_t mem_wdata;
  ptr_t   mem_raddr;
  entry_t mem_rdata;
  cmp_t   cmp;

  // Ring size is capacity plus one, never more than the memory holds.
  assign cap_ext = cnt_t'(cap_r) + cnt_t'(1);
  assign ring_n  = (cap_ext > SLOTS_N) ? SLOTS_N : cap_ext;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;

  assign is_scan = (in_req.func == FN_FIND_H) || (in_req.func == FN_FIND_X) ||
                   (in_req.func == FN_INVAL) || (in_req.func == FN_ERASE_H) ||
                   (in_req.func == FN_ERASE_HM);
  assign is_find = (req_r.func == FN_FIND_H) || (req_r.func == FN_FIND_X);

  // Outside a scan the read port keeps fetching the head entry, so a pop
  // finds it ready in its execute cycle.
  assign mem_raddr = (state_r == S_SCAN) ? scan_addr_r : rp_r;

  smrq_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  smrq_cmp u_cmp (
    .func     (req_r.func),
    .key      (req_r.key),
    .ent      (mem_rdata),
    .inv_code (inv_r),
    .res      (cmp)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    count_nxt     = count_r;
    cap_nxt       = cap_r;
    inv_nxt       = inv_r;
    scan_addr_nxt = scan_addr_r;
    left_nxt      = left_r;
    cmp_valid_nxt = cmp_valid_r;
    cmp_addr_nxt  = cmp_addr_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_waddr     = cmp_addr_r;
    mem_wdata     = cmp.fix;
    fin           = 1'b0;
    fin_res       = '0;
    out_load      = 1'b0;

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_nxt.func        = in_req.func;
          req_nxt.key.handle  = in_req.handle;
          req_nxt.key.message = in_req.message;
          req_nxt.key.param_a = in_req.param_a;
          req_nxt.key.param_b = in_req.param_b;
          if (is_scan) begin
            state_nxt     = S_SCAN;
            scan_addr_nxt = rp_r;
            left_nxt      = count_r;
            cmp_valid_nxt = 1'b0;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        fin = 1'b1;
        if (req_r.func == FN_PUSH) begin
          if ((req_r.key.handle != '0) && (count_r + cnt_t'(1) < ring_n)) begin
            mem_we     = 1'b1;
            mem_waddr  = wp_r;
            mem_wdata  = req_r.key;
            wp_nxt     = ptr_adv(wp_r, ring_n);
            count_nxt  = count_r + cnt_t'(1);
            fin_res.ok = 1'b1;
          end
        end else if (req_r.func == FN_POP) begin
          if (count_r != '0) begin
            rp_nxt      = ptr_adv(rp_r, ring_n);
            count_nxt   = count_r - cnt_t'(1);
            fin_res.ok  = 1'b1;
            fin_res.ent = mem_rdata;
          end
        end
      end
      S_SCAN: begin
        // Compare the entry read last cycle while the next one is fetched.
        if (cmp_valid_r && cmp.match) begin
          if (is_find) begin
            fin        = 1'b1;
            fin_res.ok = 1'b1;
          end else begin
            mem_we = 1'b1;
          end
        end
        if (left_r != '0) begin
          cmp_valid_nxt = 1'b1;
          cmp_addr_nxt  = scan_addr_r;
          scan_addr_nxt = ptr_adv(scan_addr_r, ring_n);
          left_nxt      = left_r - cnt_t'(1);
        end else begin
          cmp_valid_nxt = 1'b0;
          if (!cmp_valid_r) begin
            fin = 1'b1;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      fin_res.occ = count_nxt[OCC_W-1:0];
      if (out_free) begin
        out_load      = 1'b1;
        out_nxt       = fin_res;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end else begin
        res_nxt   = fin_res;
        state_nxt = S_HOLD;
      end
    end

    // A capacity write restarts the ring empty.
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY: begin
          cap_nxt   = cfg_wdata[CAP_W-1:0];
          rp_nxt    = '0;
          wp_nxt    = '0;
          count_nxt = '0;
        end
        CFG_INVALID: begin
          inv_nxt = cfg_wdata[WORD_BITS-1:0];
        end
        default: begin
          inv_nxt = inv_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      count_r     <= '0;
      cap_r       <= CAP_W'(255);
      inv_r       <= '0;
      left_r      <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      inv_r       <= inv_nxt;
      left_r      <= left_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    scan_addr_r <= scan_addr_nxt;
    cmp_addr_r  <= cmp_addr_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.ok          = out_r.ok;
  assign out_rsp.out_handle  = out_r.ent.handle;
  assign out_rsp.out_message = out_r.ent.message;
  assign out_rsp.out_param_a = out_r.ent.param_a;
  assign out_rsp.out_param_b = out_r.ent.param_b;
  assign out_rsp.occupancy   = out_r.occ;

  // The queue never holds as many entries as the ring has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < ring_n)
    else $error("queue count reached ring size");

  // Once a request is taken, the block is not ready for the next one in the cycle after.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_req.ready)
    else $error("request taken while previous one still executes");

  // A loaded response reports the occupancy the queue now has.
  a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_rsp.valid && (out_rsp.occupancy == count_r[OCC_W-1:0])))
    else $error("response occupancy disagrees with queue count");

  // The memory is written only while executing a push or scanning.
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == S_EXEC) || (state_r == S_SCAN)))
    else $error("entry memory written outside push or edit");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for searchable_message_ring_queue_core: a directed stimulus
// table, then randomized request phases under several register settings.
// Depends on smrq_pkg, smrq_req_if, smrq_rsp_if and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import smrq_pkg::*;

  // Function code 7 is unused by the block and must act as a no-op.
  localparam func_t FN_NONE = 3'd7;

  localparam int REPORT_LIMIT  = 10;
  // The slowest correct run is about 920 requests, each scanning up to 255 queued entries and
  // waiting out the longest sender gap and output stall, plus the long hold-off. The
  // limit is set well above that.
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_QUIET     = SLOTS + 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_PHASE    = 3;
  localparam int HOLD_AT       = 60;
  localparam int PAUSE_PHASE   = 5;
  localparam int PAUSE_AT      = 100;
  localparam word_t ONES       = '1;

  typedef enum {ROW_REQ, ROW_CFG} row_kind_t;

  // One row of the directed table: either a request or a register write. Rows whose
  // reply is obvious carry it typed in; the rest are checked against the model.
  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_index;
    logic [CFG_W-1:0]       reg_value;
    func_t                  func;
    entry_t                 key;
    bit                     known;
    rsp_t                   want;
  } step_row_t;

  typedef struct {
    logic [CFG_W-1:0] cap_word;
    word_t            code;
    int               items;
  } phase_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  smrq_req_if req_bus ();
  smrq_rsp_if rsp_bus ();

  searchable_message_ring_queue_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_bus),
    .out_rsp   (rsp_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Ring model. It mirrors the block's slots, pointers and both registers, and is
  // advanced once per accepted request, in acceptance order.
  // ---------------------------------------------------------------------------
  entry_t ring_mem [SLOTS];
  int     head_pos;
  int     tail_pos;
  int     cap_setting;
  word_t  void_code;

  // Replies still owed by the block, oldest first.
  rsp_t   awaited [$];

  int failures;
  int requests_sent;
  int replies_seen;
  int settings_used;
  int pushes_taken;
  int pops_given;
  int search_hits;
  int longest_stall;
  int hold_asks;
  int send_burst_left;
  int cycle_count;

  word_t handle_pool [8] = '{32'h0000_0001, 32'h0000_0002, 32'hFFFF_FFFF, 32'h8000_0000,
                             32'h1234_5678, 32'hA5A5_A5A5, 32'h0000_0100, 32'h7FFF_FFFF};
  word_t code_pool [4]   = '{32'h0000_0000, 32'h0000_0007, 32'hFFFF_FFFF, 32'hC001_D00D};

  function automatic void reset_model();
    head_pos    = 0;
    tail_pos    = 0;
    cap_setting = 255;
    void_code   = '0;
  endfunction

  // The ring uses one slot more than the capacity so that full and empty differ.
  function automatic int ring_slots();
    int n;
    n = cap_setting + 1;
    return (n > SLOTS) ? SLOTS : n;
  endfunction

  function automatic int next_pos(int p, int n);
    return (p + 1 >= n) ? 0 : p + 1;
  endfunction

  function automatic int queued_count(int n);
    return (tail_pos >= head_pos) ? tail_pos - head_pos : n - head_pos + tail_pos;
  endfunction

  // Invalidate keeps the handle; both erase forms clear it too.
  function automatic void scrub_entry(int i, bit wipe_handle);
    if (wipe_handle) ring_mem[i].handle = '0;
    ring_mem[i].message = void_code;
    ring_mem[i].param_a = '0;
    ring_mem[i].param_b = '0;
  endfunction

  function automatic rsp_t predict_reply(func_t f, entry_t key);
    rsp_t res;
    int   n;
    int   i;
    n   = ring_slots();
    res = '0;
    if (head_pos >= n) head_pos = 0;
    if (tail_pos >= n) tail_pos = 0;
    case (f)
      FN_PUSH: begin
        // A zero handle or a full ring refuses the push and leaves the ring as it is.
        if (key.handle != '0 && queued_count(n) + 1 < n) begin
          ring_mem[tail_pos] = key;
          tail_pos = next_pos(tail_pos, n);
          res.ok = 1'b1;
        end
      end
      FN_POP: begin
        if (head_pos != tail_pos) begin
          res.ent  = ring_mem[head_pos];
          head_pos = next_pos(head_pos, n);
          res.ok   = 1'b1;
        end
      end
      FN_FIND_H, FN_FIND_X: begin
        for (i = head_pos; i != tail_pos; i = next_pos(i, n)) begin
          if (ring_mem[i].handle == key.handle && (f == FN_FIND_H || ring_mem[i] == key)) begin
            res.ok = 1'b1;
            break;
          end
        end
      end
      FN_INVAL: begin
        for (i = head_pos; i != tail_pos; i = next_pos(i, n))
          if (ring_mem[i].message == key.message) scrub_entry(i, 1'b0);
      end
      FN_ERASE_H: begin
        for (i = head_pos; i != tail_pos; i = next_pos(i, n))
          if (ring_mem[i].handle == key.handle) scrub_entry(i, 1'b1);
      end
      FN_ERASE_HM: begin
        for (i = head_pos; i != tail_pos; i = next_pos(i, n))
          if (ring_mem[i].handle == key.handle && ring_mem[i].message == key.message)
            scrub_entry(i, 1'b1);
      end
      default: ;
    endcase
    res.occ = OCC_W'(queued_count(n));
    return res;
  endfunction

  // A capacity write empties the ring; only the low eight bits count.
  function automatic void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    case (idx)
      CFG_CAPACITY: begin
        cap_setting = int'(value[CAP_W-1:0]);
        head_pos    = 0;
        tail_pos    = 0;
      end
      CFG_INVALID: void_code = value;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Random request generation. Handles and codes come mostly from small pools, and
  // searches and edits usually aim at an entry that is really queued, so that hits,
  // edits and repeated matches happen often.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int next_send_gap();
    if (send_burst_left > 0) begin
      send_burst_left--;
      return 0;
    end
    if ($urandom_range(0, 99) < 2) begin
      send_burst_left = $urandom_range(20, 50);
      return 0;
    end
    return pick_gap();
  endfunction

  function automatic word_t pick_handle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 75) return handle_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic word_t pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return void_code;
    if (r < 70) return code_pool[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  function automatic word_t pick_param();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 15) return ONES;
    return $urandom;
  endfunction

  function automatic entry_t peek_queued();
    int n;
    int k;
    n = ring_slots();
    k = $urandom_range(0, queued_count(n) - 1);
    return ring_mem[(head_pos + k) % n];
  endfunction

  function automatic void roll_request(output func_t f, output entry_t key);
    int     r;
    int     bit_pos;
    entry_t hit;
    r = $urandom_range(0, 99);
    if (r < 34)      f = FN_PUSH;
    else if (r < 58) f = FN_POP;
    else if (r < 67) f = FN_FIND_H;
    else if (r < 77) f = FN_FIND_X;
    else if (r < 83) f = FN_INVAL;
    else if (r < 89) f = FN_ERASE_H;
    else if (r < 96) f = FN_ERASE_HM;
    else             f = FN_NONE;
    key.handle  = pick_handle();
    key.message = pick_code();
    key.param_a = pick_param();
    key.param_b = pick_param();
    if (queued_count(ring_slots()) > 0 && $urandom_range(0, 3) != 0) begin
      hit = peek_queued();
      case (f)
        FN_FIND_H, FN_ERASE_H: key.handle = hit.handle;
        FN_INVAL: key.message = hit.message;
        FN_ERASE_HM: begin
          key.handle  = hit.handle;
          key.message = hit.message;
        end
        FN_FIND_X: begin
          // Now and then a single flipped bit turns a sure hit into a near miss.
          key = hit;
          if ($urandom_range(0, 4) == 0) begin
            bit_pos = $urandom_range(0, 4 * WORD_BITS - 1);
            key[bit_pos] = ~key[bit_pos];
          end
        end
        default: ;
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows.
  // ---------------------------------------------------------------------------
  function automatic step_row_t row_req(func_t f, word_t h, word_t m, word_t a, word_t b);
    step_row_t row;
    row.kind      = ROW_REQ;
    row.reg_index = '0;
    row.reg_value = '0;
    row.func      = f;
    row.key       = '{h, m, a, b};
    row.known     = 1'b0;
    row.want      = '0;
    return row;
  endfunction

  function automatic step_row_t row_known(func_t f, word_t h, word_t m, word_t a, word_t b,
                                          logic ok, entry_t ent, int occ);
    step_row_t row;
    row          = row_req(f, h, m, a, b);
    row.known    = 1'b1;
    row.want.ok  = ok;
    row.want.ent = ent;
    row.want.occ = OCC_W'(occ);
    return row;
  endfunction

  function automatic step_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    step_row_t row;
    row           = row_req(FN_NONE, '0, '0, '0, '0);
    row.kind      = ROW_CFG;
    row.reg_index = idx;
    row.reg_value = value;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Reply checking. Every reply is matched against the oldest one still owed.
  // ---------------------------------------------------------------------------
  function automatic void check_reply(rsp_t got);
    rsp_t want;
    bit   bad;
    replies_seen++;
    if (awaited.size() == 0) begin
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("[%0t] reply with no request outstanding: ok=%0b %h %h %h %h occ=%0d",
                 $time, got.ok, got.ent.handle, got.ent.message, got.ent.param_a,
                 got.ent.param_b, got.occ);
    end else begin
      want = awaited.pop_front();
      bad = (got.ok !== want.ok) || (got.ent.handle !== want.ent.handle) ||
            (got.ent.message !== want.ent.message) ||
            (got.ent.param_a !== want.ent.param_a) ||
            (got.ent.param_b !== want.ent.param_b) || (got.occ !== want.occ);
      if (bad) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("[%0t] reply %0d: expected ok=%0b %h %h %h %h occ=%0d, got ok=%0b %h %h %h %h occ=%0d",
                   $time, replies_seen, want.ok, want.ent.handle, want.ent.message,
                   want.ent.param_a, want.ent.param_b, want.occ, got.ok, got.ent.handle,
                   got.ent.message, got.ent.param_a, got.ent.param_b, got.occ);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. The valid line is left high after an accepted request so that a
  // back-to-back request needs no second assignment in the same step; whoever runs
  // next either offers the next request at once or lowers valid in that same step.
  // ---------------------------------------------------------------------------
  task automatic send_request(func_t f, entry_t key, bit known, rsp_t known_rsp);
    int   gap;
    rsp_t guess;
    gap = next_send_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid   <= 1'b1;
    req_bus.func    <= f;
    req_bus.handle  <= key.handle;
    req_bus.message <= key.message;
    req_bus.param_a <= key.param_a;
    req_bus.param_b <= key.param_b;
    do @(posedge clk); while (!req_bus.ready);
    // The request was taken at this edge; the model moves on in the same order.
    guess = predict_reply(f, key);
    awaited.push_back(known ? known_rsp : guess);
    requests_sent++;
    if (guess.ok) begin
      case (f)
        FN_PUSH: pushes_taken++;
        FN_POP: pops_given++;
        default: search_hits++;
      endcase
    end
  endtask

  // Stop offering requests and wait until every owed reply has come back.
  task automatic await_idle(int extra);
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (awaited.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // The write takes effect at the edge with cfg_we high; the trailing edge keeps two
  // writes in a row from lowering and raising cfg_we in one step.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_register(idx, value);
    if (idx == CFG_CAPACITY) settings_used++;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Reply side: random ready with short and long stalls, calm stretches with ready
  // held high, and one long hold-off on request from the stimulus, counted here.
  // ---------------------------------------------------------------------------
  initial begin : reply_side
    int   stall_left;
    int   calm_left;
    int   hold_seen;
    int   stall_run;
    int   r;
    rsp_t got;
    stall_left = 0;
    calm_left  = 0;
    hold_seen  = 0;
    stall_run  = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_bus.valid) begin
        if (rsp_bus.ready) begin
          got.ok          = rsp_bus.ok;
          got.ent.handle  = rsp_bus.out_handle;
          got.ent.message = rsp_bus.out_message;
          got.ent.param_a = rsp_bus.out_param_a;
          got.ent.param_b = rsp_bus.out_param_b;
          got.occ         = rsp_bus.occupancy;
          check_reply(got);
          stall_run = 0;
        end else begin
          stall_run++;
          if (stall_run > longest_stall) longest_stall = stall_run;
        end
      end
      if (hold_asks != hold_seen) begin
        hold_seen  = hold_asks;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && calm_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 2) calm_left = $urandom_range(40, 120);
        else if (r < 27) stall_left = 1 + pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        if (calm_left > 0) calm_left--;
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d replies outstanding.", cycle_count,
               awaited.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, then random phases.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    step_row_t script [];
    phase_t    plan [6];
    func_t     f;
    entry_t    key;
    int        k;

    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_CAPACITY;
    cfg_wdata       <= '0;
    req_bus.valid   <= 1'b0;
    req_bus.func    <= FN_PUSH;
    req_bus.handle  <= '0;
    req_bus.message <= '0;
    req_bus.param_a <= '0;
    req_bus.param_b <= '0;
    reset_model();

    // The first rows run at the reset settings (capacity 255, invalid code zero):
    // the empty ring, refused zero-handle push, the no-op code and all-ones fields.
    // Then a capacity of two exercises the full ring, every edit and wrap-around,
    // and a capacity of zero leaves a ring that refuses every push.
    script = '{
      row_known(FN_POP,      '0,   '0,   '0,   '0,   1'b0, '0, 0),
      row_known(FN_PUSH,     '0,   ONES, ONES, ONES, 1'b0, '0, 0),
      row_known(FN_FIND_H,   '0,   '0,   '0,   '0,   1'b0, '0, 0),
      row_known(FN_NONE,     ONES, ONES, ONES, ONES, 1'b0, '0, 0),
      row_known(FN_PUSH,     ONES, ONES, ONES, ONES, 1'b1, '0, 1),
      row_known(FN_PUSH,     32'h1, '0,  '0,   '0,   1'b1, '0, 2),
      row_req  (FN_FIND_X,   ONES, ONES, ONES, ONES),
      row_req  (FN_FIND_X,   32'h1, '0,  '0,   32'h1),
      row_known(FN_POP,      '0,   '0,   '0,   '0,   1'b1, '{ONES, ONES, ONES, ONES}, 1),
      row_cfg  (CFG_CAPACITY, 32'hFFFF_FF02),
      row_cfg  (CFG_INVALID,  ONES),
      row_known(FN_PUSH,     32'h5, 32'h7, 32'hA, 32'hB, 1'b1, '0, 1),
      row_known(FN_PUSH,     32'h6, 32'h7, 32'hC, 32'hD, 1'b1, '0, 2),
      row_known(FN_PUSH,     32'h9, 32'h7, 32'hE, 32'hF, 1'b0, '0, 2),
      row_known(FN_INVAL,    '0,   32'h7, '0,   '0,   1'b0, '0, 2),
      row_req  (FN_FIND_H,   32'h5, '0,  '0,   '0),
      row_req  (FN_ERASE_HM, 32'h5, ONES, '0,  '0),
      row_req  (FN_ERASE_H,  32'h6, '0,  '0,   '0),
      row_req  (FN_FIND_H,   '0,   '0,   '0,   '0),
      row_req  (FN_POP,      '0,   '0,   '0,   '0),
      row_req  (FN_PUSH,     ONES, '0,   '0,   ONES),
      row_req  (FN_POP,      '0,   '0,   '0,   '0),
      row_req  (FN_POP,      '0,   '0,   '0,   '0),
      row_known(FN_POP,      '0,   '0,   '0,   '0,   1'b0, '0, 0),
      row_cfg  (CFG_CAPACITY, 32'h0000_0000),
      row_known(FN_PUSH,     32'h3, 32'h3, 32'h3, 32'h3, 1'b0, '0, 0),
      row_known(FN_POP,      '0,   '0,   '0,   '0,   1'b0, '0, 0)
    };

    // Random phases: small rings that fill often, the one-slot ring, a medium ring
    // that takes the long output hold-off, the largest ring, and a mid-phase pause.
    plan[0] = '{32'h0000_0003, ONES,          150};
    plan[1] = '{32'hFFFF_FF01, 32'h0,         80};
    plan[2] = '{32'h0000_0000, 32'h1357_9BDF, 30};
    plan[3] = '{32'h0000_0010, 32'h8000_0001, 200};
    plan[4] = '{32'h0000_00FF, 32'h0,         240};
    plan[5] = '{32'h0000_0008, 32'hC0DE_0000, 200};
    plan[2].code = $urandom;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        await_idle(SETTLE_CYCLES);
        write_reg(script[i].reg_index, script[i].reg_value);
      end else begin
        send_request(script[i].func, script[i].key, script[i].known, script[i].want);
      end
    end

    foreach (plan[p]) begin
      await_idle(SETTLE_CYCLES);
      write_reg(CFG_CAPACITY, plan[p].cap_word);
      write_reg(CFG_INVALID, plan[p].code);
      for (k = 0; k < plan[p].items; k++) begin
        // The hold-off lets the block fill up and push back on requests; the pause
        // lets every owed reply drain before requests resume.
        if (p == HOLD_PHASE && k == HOLD_AT) hold_asks++;
        if (p == PAUSE_PHASE && k == PAUSE_AT) await_idle(0);
        roll_request(f, key);
        send_request(f, key, 1'b0, '0);
      end
    end

    await_idle(0);
    repeat (END_QUIET) @(posedge clk);

    if (awaited.size() != 0) begin
      failures += awaited.size();
      $display("%0d replies never arrived.", awaited.size());
    end

    $display("Ran %0d requests under %0d capacity settings and checked %0d replies.",
             requests_sent, settings_used, replies_seen);
    $display("Pushes taken %0d, pops delivered %0d, search hits %0d, longest output stall %0d.",
             pushes_taken, pops_given, search_hits, longest_stall);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
